FILE: design/utf8_to_utf16_transcoder_assert.svh
// Assertion macros shared by the UTF-8 to UTF-16 transcoder modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define U8U16_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define U8U16_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/u8u16_pkg.sv
`timescale 1ns / 1ps
// Package for the UTF-8 to UTF-16 transcoder: status codes, job record,
// byte classification helpers. No dependencies.
package u8u16_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ILLEGAL   = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  // Byte and code point limits
  localparam logic [7:0]  LEAD_MAX      = 8'hF4;
  localparam logic [7:0]  LEAD_MIN      = 8'hC2;
  localparam logic [7:0]  TRAIL_LO      = 8'h80;
  localparam logic [7:0]  TRAIL_HI      = 8'hBF;
  localparam logic [7:0]  E0_SECOND_MIN = 8'hA0;
  localparam logic [7:0]  ED_SECOND_MAX = 8'h9F;
  localparam logic [7:0]  F0_SECOND_MIN = 8'h90;
  localparam logic [7:0]  F4_SECOND_MAX = 8'h8F;
  localparam logic [7:0]  LEAD_E0       = 8'hE0;
  localparam logic [7:0]  LEAD_ED       = 8'hED;
  localparam logic [7:0]  LEAD_F0       = 8'hF0;
  localparam logic [7:0]  LEAD_F4       = 8'hF4;
  localparam logic [20:0] CP_SUPP_BASE  = 21'h010000;
  localparam logic [20:0] CP_MAX        = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO    = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI    = 21'h00DFFF;
  localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
  localparam logic [15:0] REPLACEMENT   = 16'hFFFD;

  // Default depth of the job queue between front and back
  localparam int JOBQ_DEPTH = 2;

  // Kind of work handed from front to back
  typedef enum logic [1:0] {
    JOB_UNIT,
    JOB_PAIR,
    JOB_ERR
  } job_kind_t;

  // One job: a single unit, a supplementary code point less 0x10000, or an error
  typedef struct packed {
    job_kind_t   kind;
    logic [1:0]  status;
    logic [19:0] data;
  } job_t;

  // Sequence length called for by a lead byte
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (b < 8'hC0)      len = 3'd1;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF8) len = 3'd4;
    else if (b < 8'hFC) len = 3'd5;
    else                len = 3'd6;
    return len;
  endfunction

  // Payload bits kept from a lead byte for a given length
  function automatic logic [7:0] lead_bits(input logic [7:0] b, input logic [2:0] len);
    logic [7:0] mask;
    case (len)
      3'd1:    mask = 8'h7F;
      3'd2:    mask = 8'h1F;
      3'd3:    mask = 8'h0F;
      3'd4:    mask = 8'h07;
      3'd5:    mask = 8'h03;
      3'd6:    mask = 8'h01;
      default: mask = 8'h00;
    endcase
    return b & mask;
  endfunction

endpackage

FILE: design/u8u16_front.sv
`timescale 1ns / 1ps
// Front end: accepts UTF-8 bytes, tracks the current sequence, checks
// legality and emits one job per finished sequence or error. Uses u8u16_pkg.
module u8u16_front import u8u16_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_strict_mode,
  input  logic       byte_vld_i,
  input  logic [7:0] byte_i,
  input  logic       eos_i,
  output logic       job_vld_o,
  output job_t       job_o
);

  logic        strict_r;
  logic [2:0]  pend_r, pend_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic        ill_r, ill_nxt;
  logic        halt_r, halt_nxt;

  logic [2:0]  new_len;
  logic        second;
  logic        trail_ok;
  logic [20:0] cp_supp;

  // Hold the strictness setting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b1;
    end else if (cfg_wr_en) begin
      strict_r <= cfg_strict_mode;
    end
  end

  // Check a trailing byte, with tighter second-byte ranges after some leads
  always_comb begin
    second   = ((pend_r + 3'd1) == len_r);
    trail_ok = (byte_i >= TRAIL_LO) && (byte_i <= TRAIL_HI);
    if (second) begin
      case (lead_r)
        LEAD_E0: trail_ok = trail_ok && (byte_i >= E0_SECOND_MIN);
        LEAD_ED: trail_ok = trail_ok && (byte_i <= ED_SECOND_MAX);
        LEAD_F0: trail_ok = trail_ok && (byte_i >= F0_SECOND_MIN);
        LEAD_F4: trail_ok = trail_ok && (byte_i <= F4_SECOND_MAX);
        default: trail_ok = trail_ok;
      endcase
    end
  end

  assign new_len = seq_len(byte_i);
  assign cp_supp = cp_nxt - CP_SUPP_BASE;

  // Advance the sequence state and decide on a job
  always_comb begin
    pend_nxt  = pend_r;
    len_nxt   = len_r;
    lead_nxt  = lead_r;
    cp_nxt    = cp_r;
    ill_nxt   = ill_r;
    halt_nxt  = halt_r;
    job_vld_o = 1'b0;
    job_o     = '{kind: JOB_ERR, status: ST_ILLEGAL, data: '0};

    if (byte_vld_i) begin
      if (halt_r) begin
        // drop bytes through the end of the stream
        if (eos_i) halt_nxt = 1'b0;
      end else begin
        if (pend_r == 3'd0) begin
          len_nxt  = new_len;
          lead_nxt = byte_i;
          ill_nxt  = (new_len >= 3'd5) || ((byte_i >= TRAIL_LO) && (byte_i < LEAD_MIN))
                     || (byte_i > LEAD_MAX);
          cp_nxt   = {13'd0, lead_bits(byte_i, new_len)};
          pend_nxt = new_len - 3'd1;
        end else begin
          if (!trail_ok) ill_nxt = 1'b1;
          cp_nxt   = {cp_r[14:0], byte_i[5:0]};
          pend_nxt = pend_r - 3'd1;
        end

        if (pend_nxt != 3'd0) begin
          // cut off by the end of the stream
          if (eos_i) begin
            job_vld_o = 1'b1;
            job_o     = '{kind: JOB_ERR, status: ST_EXHAUSTED, data: '0};
            pend_nxt  = 3'd0;
            halt_nxt  = 1'b0;
          end
        end else if (ill_nxt) begin
          job_vld_o = 1'b1;
          job_o     = '{kind: JOB_ERR, status: ST_ILLEGAL, data: '0};
          halt_nxt  = !eos_i;
        end else begin
          job_vld_o = 1'b1;
          if (((cp_nxt >= CP_SURR_LO) && (cp_nxt <= CP_SURR_HI)) || (cp_nxt > CP_MAX)) begin
            if (strict_r) begin
              job_o    = '{kind: JOB_ERR, status: ST_ILLEGAL, data: '0};
              halt_nxt = !eos_i;
            end else begin
              job_o = '{kind: JOB_UNIT, status: ST_OK, data: {4'd0, REPLACEMENT}};
            end
          end else if (cp_nxt < CP_SUPP_BASE) begin
            job_o = '{kind: JOB_UNIT, status: ST_OK, data: {4'd0, cp_nxt[15:0]}};
          end else begin
            job_o = '{kind: JOB_PAIR, status: ST_OK, data: cp_supp[19:0]};
          end
        end
      end
    end
  end

  // Register the sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      len_r  <= '0;
      lead_r <= '0;
      cp_r   <= '0;
      ill_r  <= 1'b0;
      halt_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      len_r  <= len_nxt;
      lead_r <= lead_nxt;
      cp_r   <= cp_nxt;
      ill_r  <= ill_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

FILE: design/u8u16_jobq.sv
`timescale 1ns / 1ps
// Job queue between the front end and the back end.
// Small register FIFO of job_t records. Uses u8u16_pkg.
`include "utf8_to_utf16_transcoder_assert.svh"
module u8u16_jobq import u8u16_pkg::*; #(
  parameter int DEPTH = JOBQ_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic vld_o,
  output job_t job_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign full_o = (cnt_r == CNT_W'(DEPTH));
  assign vld_o  = (cnt_r != '0);
  assign job_o  = slot_r[rd_ptr_r];
  assign do_pop = pop_i && vld_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push_i && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Write the slot
  always_ff @(posedge clk) begin
    if (push_i) slot_r[wr_ptr_r] <= job_i;
  end

  `U8U16_ASSERT_NOW(a_no_push_when_full, push_i, cnt_r < CNT_W'(DEPTH), "job pushed into full queue")
  `U8U16_ASSERT_NEXT(a_count_tracks_push, push_i && !do_pop, cnt_r == $past(cnt_r) + 1'b1, "lost push")
  `U8U16_ASSERT_NEXT(a_count_tracks_pop, do_pop && !push_i, cnt_r == $past(cnt_r) - 1'b1, "lost pop")

endmodule

FILE: design/u8u16_back.sv
`timescale 1ns / 1ps
// Back end: turns jobs into UTF-16 result items in an output register,
// splitting supplementary code points into surrogate pairs. Uses u8u16_pkg.
`include "utf8_to_utf16_transcoder_assert.svh"
module u8u16_back import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_vld_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  output logic        out_vld_o,
  input  logic        out_pop_i,
  output logic [15:0] out_code_unit_o,
  output logic [1:0]  out_status_o,
  output logic        out_last_o
);

  logic        out_vld_r, out_vld_nxt;
  logic [15:0] unit_r, unit_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        last_r, last_nxt;
  logic        lo_pend_r, lo_pend_nxt;
  logic [9:0]  lo_bits_r, lo_bits_nxt;
  logic        load_ok;

  // Output slot is free when empty or being taken this cycle
  assign load_ok   = !out_vld_r || out_pop_i;
  assign job_pop_o = load_ok && !lo_pend_r && job_vld_i;

  // Load the next item: a pending low surrogate first, then a new job
  always_comb begin
    out_vld_nxt = out_vld_r;
    unit_nxt    = unit_r;
    status_nxt  = status_r;
    last_nxt    = last_r;
    lo_pend_nxt = lo_pend_r;
    lo_bits_nxt = lo_bits_r;
    if (load_ok) begin
      out_vld_nxt = 1'b0;
      if (lo_pend_r) begin
        out_vld_nxt = 1'b1;
        unit_nxt    = LO_SURR_BASE + {6'd0, lo_bits_r};
        status_nxt  = ST_OK;
        last_nxt    = 1'b1;
        lo_pend_nxt = 1'b0;
      end else if (job_vld_i) begin
        out_vld_nxt = 1'b1;
        status_nxt  = job_i.status;
        case (job_i.kind)
          JOB_UNIT: begin
            unit_nxt = job_i.data[15:0];
            last_nxt = 1'b1;
          end
          JOB_PAIR: begin
            unit_nxt    = HI_SURR_BASE + {6'd0, job_i.data[19:10]};
            last_nxt    = 1'b0;
            lo_pend_nxt = 1'b1;
            lo_bits_nxt = job_i.data[9:0];
          end
          default: begin
            unit_nxt = '0;
            last_nxt = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      lo_pend_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      lo_pend_r <= lo_pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unit_r    <= unit_nxt;
    status_r  <= status_nxt;
    last_r    <= last_nxt;
    lo_bits_r <= lo_bits_nxt;
  end

  assign out_vld_o       = out_vld_r;
  assign out_code_unit_o = unit_r;
  assign out_status_o    = status_r;
  assign out_last_o      = last_r;

  `U8U16_ASSERT_NOW(a_lo_needs_hi, lo_pend_r, out_vld_r && !last_r, "low surrogate pending without high in output")
  `U8U16_ASSERT_NOW(a_hi_has_lo, out_vld_r && !last_r, lo_pend_r, "high surrogate shown with no low pending")
  `U8U16_ASSERT_NOW(a_err_shape, out_vld_r && (status_r != ST_OK), (unit_r == '0) && last_r, "error item not zero or not last")

endmodule

FILE: design/utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps
// UTF-8 to UTF-16 transcoder, top level.
// Input side is a queue write port: drive in_byte and in_end_of_stream with
// push; a byte is taken at a clock edge where push is high and full is low.
// Result side is a queue read port: while empty is low the oldest result sits
// on out_code_unit, out_status, out_last_of_run; pop high takes it.
// A byte taken at a clock edge is decoded in the cycle before it; its job goes
// through the job queue into the back end's single output register. While full
// is low one byte per cycle is taken; a surrogate pair gives two result items,
// high then low, which the job queue (JOBQ_DEPTH entries) absorbs; full rises
// when it fills or when the reader stops popping. Bytes that complete no
// sequence produce no result, save an end-of-stream byte cutting one off
// (exhausted error). After an error, bytes are dropped through the next
// end-of-stream byte. cfg_wr_en with cfg_strict_mode sets strict mode; write it
// only while the block is idle. Reset (rst_n low, synchronous) empties the
// queue and output, clears the sequence state and sets strict mode to 1.
module utf8_to_utf16_transcoder import u8u16_pkg::*; #(
  parameter int JOBQ_DEPTH_P = JOBQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_strict_mode,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_stream,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_code_unit,
  output logic [1:0]  out_status,
  output logic        out_last_of_run
);

  logic byte_vld;
  logic job_push;
  job_t job_in;
  logic job_vld;
  job_t job_out;
  logic job_pop;
  logic out_vld;

  assign byte_vld = push && !full;
  assign empty    = !out_vld;

  u8u16_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_strict_mode (cfg_strict_mode),
    .byte_vld_i      (byte_vld),
    .byte_i          (in_byte),
    .eos_i           (in_end_of_stream),
    .job_vld_o       (job_push),
    .job_o           (job_in)
  );

  u8u16_jobq #(
    .DEPTH (JOBQ_DEPTH_P)
  ) u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (job_push),
    .job_i  (job_in),
    .full_o (full),
    .pop_i  (job_pop),
    .vld_o  (job_vld),
    .job_o  (job_out)
  );

  u8u16_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_vld_i       (job_vld),
    .job_i           (job_out),
    .job_pop_o       (job_pop),
    .out_vld_o       (out_vld),
    .out_pop_i       (pop),
    .out_code_unit_o (out_code_unit),
    .out_status_o    (out_status),
    .out_last_o      (out_last_of_run)
  );

endmodule
